FILE: rtl/tcc_pkg.sv
package tcc_pkg;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CMD_W   = 2;
  localparam int POS_W   = 12;
  localparam int RGB_W   = 16;
  localparam int RES_W   = 13;   // resolution registers and cursor_y

  localparam logic [RES_W-1:0] RES_LIMIT = 13'd4096;

  localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CHAR_W-1:0] glyph_code;
    logic [RGB_W-1:0]  pixel_color;
    logic              last;
  } cmd_t;

endpackage

FILE: rtl/tcc_char_if.sv
interface tcc_char_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source(output valid, output char_code, output red, output green, output blue,
                 input ready);
  modport sink(input valid, input char_code, input red, input green, input blue,
               output ready);
endinterface

FILE: rtl/tcc_cmd_if.sv
interface tcc_cmd_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [CHAR_W-1:0] glyph_code;
  logic [RGB_W-1:0]  pixel_color;
  logic              last;

  modport source(output valid, output command, output pos_x, output pos_y,
                 output glyph_code, output pixel_color, output last, input ready);
  modport sink(input valid, input command, input pos_x, input pos_y,
               input glyph_code, input pixel_color, input last, output ready);
endinterface

FILE: rtl/text_console_cursor_top.sv
// Channel  Dir  Handshake    Payload
// chars    in   valid/ready  char_code, red, green, blue
// cmds     out  valid/ready  command, pos_x, pos_y, glyph_code, pixel_color, last
// cfg      in   cfg_we       cfg_index, cfg_data (no read-back)
//
// An item is taken into the input register, then it updates the cursor and
// loads zero, one or two commands into a two-slot output buffer at the same time.
// Throughput is set by the output buffer: one command per cycle while cmds.ready
// is high. An item is processed only once the buffer will be empty, and its way
// from input handshake to first command runs through the input register and slot0.
// The input register refills while commands still wait in the buffer.
// Reset (rst, synchronous) homes the cursor, empties both stages and loads
// the default 1024x768 screen; chars.ready stays low while rst is high.
// Config writes update cell-rounded sizes at once.
module text_console_cursor_top #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tcc_pkg::RES_W-1:0]  cfg_data,
  tcc_char_if.sink                   chars,
  tcc_cmd_if.source                  cmds
);
  import tcc_pkg::*;

  // Cell sizes at resolution-register width
  localparam logic [RES_W-1:0] GW = RES_W'(GLYPH_WIDTH);
  localparam logic [RES_W-1:0] GH = RES_W'(GLYPH_HEIGHT);
  localparam logic [RES_W:0]   GW2 = (RES_W+1)'(2 * GLYPH_WIDTH);

  // floor(2^16 / d): with v <= 4096 the estimate is at most one low
  localparam int unsigned RECIP_W = 65536 / GLYPH_WIDTH;
  localparam int unsigned RECIP_H = 65536 / GLYPH_HEIGHT;

  // Reset values of the derived screen geometry
  localparam int unsigned COLS_PX_RST = (1024 / GLYPH_WIDTH) * GLYPH_WIDTH;
  localparam int unsigned ROWS_PX_RST = (768 / GLYPH_HEIGHT) * GLYPH_HEIGHT;
  localparam int unsigned LAST_ROW_RST =
      (ROWS_PX_RST > 0) ? ROWS_PX_RST - GLYPH_HEIGHT : 0;

  // Largest multiple of d not above v
  function automatic logic [RES_W-1:0] round_down(input logic [RES_W-1:0] v,
                                                  input int unsigned d,
                                                  input int unsigned recip);
    logic [28:0]      prod;
    logic [RES_W-1:0] q;
    logic [RES_W-1:0] base;
    logic [RES_W-1:0] rem;
    prod = 29'(v) * 29'(recip);
    q    = RES_W'(prod >> 16);
    base = RES_W'(32'(q) * d);
    rem  = v - base;
    if (rem >= RES_W'(d)) begin
      base = base + RES_W'(d);
    end
    return base;
  endfunction

  // Screen geometry, kept in cell-rounded form
  logic [RES_W-1:0] width;      // clamped screen width
  logic [RES_W-1:0] cols_px;    // columns * GLYPH_WIDTH
  logic [RES_W-1:0] rows_px;    // rows * GLYPH_HEIGHT
  logic [RES_W-1:0] last_row;   // y of the last text row

  logic [RES_W-1:0] cfg_clamp;
  logic [RES_W-1:0] cfg_round_w;
  logic [RES_W-1:0] cfg_round_h;

  always_comb begin
    cfg_clamp   = (cfg_data > RES_LIMIT) ? RES_LIMIT : cfg_data;
    cfg_round_w = round_down(cfg_clamp, GLYPH_WIDTH, RECIP_W);
    cfg_round_h = round_down(cfg_clamp, GLYPH_HEIGHT, RECIP_H);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width    <= RES_W'(1024);
      cols_px  <= RES_W'(COLS_PX_RST);
      rows_px  <= RES_W'(ROWS_PX_RST);
      last_row <= RES_W'(LAST_ROW_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH: begin
          width   <= cfg_clamp;
          cols_px <= cfg_round_w;
        end
        REG_SCREEN_HEIGHT: begin
          rows_px  <= cfg_round_h;
          last_row <= (cfg_round_h != '0) ? cfg_round_h - GH : '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Input register
  logic               in_vld;
  logic [CHAR_W-1:0]  in_char;
  logic [COLOR_W-1:0] in_red;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_blue;

  // Output buffer: slot0 is at the port, slot1 follows
  cmd_t       slot0;
  cmd_t       slot1;
  logic [1:0] cnt;

  logic pop;
  logic process;

  assign pop     = cmds.valid && cmds.ready;
  // Load results only when the buffer is empty by the end of this cycle
  assign process = in_vld && ((cnt == 2'd0) || ((cnt == 2'd1) && pop));
  assign chars.ready = !rst && (!in_vld || process);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      in_vld <= 1'b1;
    end else if (process) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char  <= chars.char_code;
      in_red   <= chars.red;
      in_green <= chars.green;
      in_blue  <= chars.blue;
    end
  end

  // Cursor
  logic [POS_W-1:0] cursor_x;
  logic [RES_W-1:0] cursor_y;
  logic [POS_W-1:0] cursor_x_next;
  logic [RES_W-1:0] cursor_y_next;

  cmd_t       res_a;
  cmd_t       res_b;
  logic [1:0] res_n;

  logic             is_bs;
  logic             is_nl;
  logic             scroll;
  logic [RES_W-1:0] y_row;   // cursor y after any scroll
  logic [RGB_W-1:0] rgb565;
  cmd_t             draw;
  cmd_t             scr;

  always_comb begin
    is_bs  = (in_char == CH_BACKSPACE);
    is_nl  = (in_char == CH_NEWLINE);
    scroll = (cursor_y >= rows_px);
    y_row  = scroll ? last_row : cursor_y;
    rgb565 = {in_red[7:3], in_green[7:2], in_blue[7:3]};

    scr.command     = CMD_SCROLL;
    scr.pos_x       = '0;
    scr.pos_y       = last_row[POS_W-1:0];
    scr.glyph_code  = '0;
    scr.pixel_color = '0;
    scr.last        = is_nl;

    draw.command     = CMD_DRAW;
    draw.pos_x       = cursor_x;
    draw.pos_y       = y_row[POS_W-1:0];
    draw.glyph_code  = in_char;
    draw.pixel_color = rgb565;
    draw.last        = 1'b1;

    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    res_a = draw;
    res_b = draw;
    res_n = 2'd0;

    if (is_bs) begin
      // Backspace never scrolls; at the home position it does nothing
      if (cursor_x != '0 || cursor_y != '0) begin
        if (cursor_x == '0) begin
          cursor_y_next = (cursor_y >= GH) ? cursor_y - GH : '0;
          cursor_x_next = (cols_px != '0) ? POS_W'(cols_px - GW) : '0;
        end else begin
          cursor_x_next = ({1'b0, cursor_x} >= GW) ? POS_W'({1'b0, cursor_x} - GW) : '0;
        end
        res_a.command     = CMD_CLEAR;
        res_a.pos_x       = cursor_x_next;
        res_a.pos_y       = cursor_y_next[POS_W-1:0];
        res_a.glyph_code  = '0;
        res_a.pixel_color = '0;
        res_a.last        = 1'b1;
        res_n = 2'd1;
      end
    end else if (is_nl) begin
      res_a = scr;
      res_n = {1'b0, scroll};
      cursor_x_next = '0;
      cursor_y_next = y_row + GH;
    end else begin
      if (scroll) begin
        res_a = scr;
        res_b = draw;
        res_n = 2'd2;
      end else begin
        res_a = draw;
        res_n = 2'd1;
      end
      // Wrap when the next cell would not fit
      if ({2'b00, cursor_x} + GW2 > {1'b0, width}) begin
        cursor_x_next = '0;
        cursor_y_next = y_row + GH;
      end else begin
        cursor_x_next = cursor_x + GW[POS_W-1:0];
        cursor_y_next = y_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (process) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (process) begin
      cnt <= res_n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      slot0 <= res_a;
      slot1 <= res_b;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign cmds.valid       = (cnt != 2'd0);
  assign cmds.command     = slot0.command;
  assign cmds.pos_x       = slot0.pos_x;
  assign cmds.pos_y       = slot0.pos_y;
  assign cmds.glyph_code  = slot0.glyph_code;
  assign cmds.pixel_color = slot0.pixel_color;
  assign cmds.last        = slot0.last;

endmodule

FILE: sim/text_console_cursor_top_tb.sv
module text_console_cursor_top_tb;
  import tcc_pkg::*;

  // Cell geometry; must match the parameters handed to the block
  localparam int GLYPH_W = 8;
  localparam int GLYPH_H = 16;
  // Cycles given to the block to retire an item that makes no command
  localparam int DRAIN_CYCLES = 6;
  // Cycles with no handshake at all before the run is declared hung
  localparam int HANG_LIMIT = 2000;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } char_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_SCREEN_WIDTH;
  logic [RES_W-1:0] cfg_data  = '0;

  // Driven copies of the channel inputs, known from time zero
  logic       char_valid = 1'b0;
  char_item_t char_data  = '0;
  logic       cmd_ready  = 1'b0;

  tcc_char_if chars_if();
  tcc_cmd_if  cmds_if();

  assign chars_if.valid     = char_valid;
  assign chars_if.char_code = char_data.char_code;
  assign chars_if.red       = char_data.red;
  assign chars_if.green     = char_data.green;
  assign chars_if.blue      = char_data.blue;
  assign cmds_if.ready      = cmd_ready;

  text_console_cursor_top #(
    .GLYPH_WIDTH (GLYPH_W),
    .GLYPH_HEIGHT(GLYPH_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .chars    (chars_if),
    .cmds     (cmds_if)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cursor predictor: its own copy of the screen size and cursor position.
  // Updated when an item is accepted; pushes the commands that item must make.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] cur_x = '0;
  logic [RES_W-1:0] cur_y = '0;
  logic [RES_W-1:0] scr_w = 13'd1024;
  logic [RES_W-1:0] scr_h = 13'd768;

  cmd_t cmd_expect[$];
  int   fail_count = 0;

  function automatic cmd_t make_cmd(logic [CMD_W-1:0] op, int x, int y,
                                    logic [CHAR_W-1:0] glyph, logic [RGB_W-1:0] color,
                                    logic fin);
    cmd_t c;
    c.command     = op;
    c.pos_x       = POS_W'(x);
    c.pos_y       = POS_W'(y);
    c.glyph_code  = glyph;
    c.pixel_color = color;
    c.last        = fin;
    return c;
  endfunction

  function automatic void advance_cursor(char_item_t it);
    int   w, h, cols, rows, bottom, x, y;
    cmd_t scroll_cmd;
    bit   scrolled;
    w = (scr_w > RES_LIMIT) ? int'(RES_LIMIT) : int'(scr_w);
    h = (scr_h > RES_LIMIT) ? int'(RES_LIMIT) : int'(scr_h);
    cols = w / GLYPH_W;
    rows = h / GLYPH_H;
    bottom = (rows > 0) ? (rows - 1) * GLYPH_H : 0;
    x = int'(cur_x);
    y = int'(cur_y);
    scrolled = 1'b0;

    if (it.char_code == CH_BACKSPACE) begin
      // top-left corner: nothing to erase
      if (x == 0 && y == 0) return;
      if (x == 0) begin
        // back to the last cell of the previous row
        y = (y >= GLYPH_H) ? y - GLYPH_H : 0;
        x = (cols > 0) ? ((cols - 1) * GLYPH_W) & 12'hFFF : 0;
      end else begin
        x = (x >= GLYPH_W) ? x - GLYPH_W : 0;
      end
      cur_x = POS_W'(x);
      cur_y = RES_W'(y);
      cmd_expect.push_back(make_cmd(CMD_CLEAR, x, y, '0, '0, 1'b1));
      return;
    end

    // below the last text row: scroll first, cursor lands on the last row
    if (y >= rows * GLYPH_H) begin
      scroll_cmd = make_cmd(CMD_SCROLL, 0, bottom, '0, '0, 1'b0);
      scrolled = 1'b1;
      y = bottom;
    end

    if (it.char_code == CH_NEWLINE) begin
      if (scrolled) begin
        scroll_cmd.last = 1'b1;
        cmd_expect.push_back(scroll_cmd);
      end
      cur_y = RES_W'((y + GLYPH_H) & 13'h1FFF);
      cur_x = '0;
      return;
    end

    if (scrolled) cmd_expect.push_back(scroll_cmd);
    cmd_expect.push_back(make_cmd(CMD_DRAW, x, y, it.char_code,
                                  {it.red[7:3], it.green[7:2], it.blue[7:3]}, 1'b1));
    // wrap when the next cell would not fit
    if (x + 2 * GLYPH_W > w) begin
      x = 0;
      y = (y + GLYPH_H) & 13'h1FFF;
    end else begin
      x = (x + GLYPH_W) & 12'hFFF;
    end
    cur_x = POS_W'(x);
    cur_y = RES_W'(y);
  endfunction

  // Random wait per item, with occasional runs of back-to-back items
  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run = $urandom_range(10, 40);
    return $urandom_range(0, 19);
  endfunction

  // ---------------------------------------------------------------------------
  // Character driver: feeds items from the pending queue, gap drawn per item
  // ---------------------------------------------------------------------------
  char_item_t pending[$];
  int send_gap = 0;
  int send_run = 0;

  always @(posedge clk) begin
    logic       v_next;
    char_item_t d_next;
    v_next = char_valid;
    d_next = char_data;
    if (rst) begin
      v_next   = 1'b0;
      send_gap = 0;
    end else begin
      if (char_valid && chars_if.ready) begin
        advance_cursor(char_data);
        v_next   = 1'b0;
        send_gap = draw_wait(send_run);
      end
      if (!v_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() != 0) begin
          d_next = pending.pop_front();
          v_next = 1'b1;
        end
      end
    end
    // one assignment per step, so valid held high for a follow-on item stays high
    char_valid <= v_next;
    char_data  <= d_next;
  end

  // ---------------------------------------------------------------------------
  // Command monitor: checks each accepted command against the oldest
  // expectation, then stalls ready for a drawn number of cycles
  // ---------------------------------------------------------------------------
  int recv_wait = 0;
  int recv_run  = 0;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    logic r_next;
    cmd_t want;
    r_next = cmd_ready;
    if (rst) begin
      r_next    = 1'b0;
      recv_wait = 0;
    end else if (cmds_if.valid && cmd_ready) begin
      if (cmd_expect.size() == 0) begin
        $error("command %0d at (%0d,%0d) with nothing expected",
               cmds_if.command, cmds_if.pos_x, cmds_if.pos_y);
        fail_count++;
      end else begin
        want = cmd_expect.pop_front();
        check_field("command",     32'(want.command),     32'(cmds_if.command));
        check_field("pos_x",       32'(want.pos_x),       32'(cmds_if.pos_x));
        check_field("pos_y",       32'(want.pos_y),       32'(cmds_if.pos_y));
        check_field("glyph_code",  32'(want.glyph_code),  32'(cmds_if.glyph_code));
        check_field("pixel_color", 32'(want.pixel_color), 32'(cmds_if.pixel_color));
        check_field("last",        32'(want.last),        32'(cmds_if.last));
      end
      recv_wait = draw_wait(recv_run);
      r_next = (recv_wait == 0);
    end else if (recv_wait > 0) begin
      recv_wait--;
      r_next = (recv_wait == 0);
    end else begin
      r_next = 1'b1;
    end
    cmd_ready <= r_next;
  end

  // Hang detector: any handshake or register write counts as progress
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_we || (char_valid && chars_if.ready) || (cmds_if.valid && cmd_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("text_console_cursor_top_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_char(logic [7:0] c, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pending.push_back({c, r, g, b});
  endtask

  // Mostly text with random bytes and colors; newlines and backspace runs mixed in.
  // Backspace runs are long enough to walk back across row starts.
  task automatic queue_text(int n, int nl_pct, int bs_pct);
    int k, pick, run;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      if (pick < bs_pct) begin
        run = $urandom_range(1, 6);
        repeat (run) queue_char(CH_BACKSPACE, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        k += run;
      end else begin
        queue_char((pick < bs_pct + nl_pct) ? CH_NEWLINE : 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        k++;
      end
    end
  endtask

  // Block goes idle: all items in, all commands out, then DRAIN_CYCLES more for
  // a trailing item that makes no command
  task automatic drain();
    while (pending.size() != 0 || char_valid || cmd_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called while idle; predictor copy follows the write
  task automatic set_screen(logic [RES_W-1:0] w, logic [RES_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= w;
    scr_w = w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    scr_h = h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- reset screen, 128 x 48 cells ---
    queue_char(CH_BACKSPACE, 8'h00, 8'h00, 8'h00);  // top-left: no command
    queue_char(CH_NEWLINE,   8'hFF, 8'hFF, 8'hFF);  // plain newline, no scroll
    queue_char(CH_BACKSPACE, 8'hFF, 8'h00, 8'hFF);  // row start: to last cell above
    queue_char(8'h41, 8'hFF, 8'h00, 8'h00);         // last column: wraps
    queue_char(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_char(8'h00, 8'h00, 8'h00, 8'h00);
    queue_char(8'h55, 8'hAA, 8'h55, 8'hAA);
    queue_char(8'hAA, 8'h55, 8'hAA, 8'h55);
    queue_char(CH_BACKSPACE, 8'h12, 8'h34, 8'h56);  // mid-row step back
    queue_char(CH_BACKSPACE, 8'h00, 8'h00, 8'h00);
    queue_char(CH_NEWLINE,   8'h00, 8'h00, 8'h00);
    drain();

    // --- smallest legal screen: 2 x 2 cells ---
    set_screen(13'd16, 13'd32);
    queue_char(8'h61, 8'h80, 8'h40, 8'h20);
    queue_char(8'h62, 8'h08, 8'h04, 8'h08);
    queue_char(8'h63, 8'hF8, 8'hFC, 8'hF8);
    queue_char(8'h64, 8'h07, 8'h03, 8'h07);         // cursor ends below the last row
    queue_char(CH_BACKSPACE, 8'h00, 8'h00, 8'h00);  // below last row: no scroll
    queue_char(8'h65, 8'h11, 8'h22, 8'h33);
    queue_char(CH_NEWLINE,   8'h00, 8'h00, 8'h00);  // newline that only scrolls
    queue_char(8'h66, 8'hFF, 8'hFF, 8'hFF);         // scroll then draw
    queue_text(130, 10, 15);
    drain();

    // --- zero columns and zero rows: every character but backspace scrolls ---
    set_screen(13'd0, 13'd0);
    queue_char(8'h78, 8'hC0, 8'hC0, 8'hC0);
    queue_char(CH_BACKSPACE, 8'h00, 8'h00, 8'h00);  // row start with no columns
    queue_char(CH_NEWLINE,   8'h00, 8'h00, 8'h00);
    queue_text(30, 15, 20);
    drain();

    // --- screen narrower than two cells: wraps after every glyph ---
    set_screen(13'd8, 13'd48);
    queue_text(60, 10, 20);
    drain();

    // --- oversized registers, clamped to 4096: newline-heavy to reach the bottom ---
    set_screen(13'h1FFF, 13'h1FFF);
    queue_text(320, 85, 3);
    drain();

    // --- largest legal screen ---
    set_screen(13'd4096, 13'd4096);
    queue_text(60, 20, 20);
    drain();

    // --- mid-size screens, two with sizes that are not whole cells ---
    set_screen(13'd40, 13'd80);
    queue_text(220, 8, 15);
    drain();

    set_screen(13'd100, 13'd50);
    queue_text(220, 6, 30);
    drain();

    set_screen(13'd24, 13'd40);
    queue_text(110, 10, 15);
    drain();

    if (fail_count == 0 && cmd_expect.size() == 0) begin
      $display("text_console_cursor_top_tb passed");
    end else begin
      $display("text_console_cursor_top_tb failed");
    end
    $finish;
  end

endmodule

FILE: text_console_cursor_top.f
rtl/tcc_pkg.sv
rtl/tcc_char_if.sv
rtl/tcc_cmd_if.sv
rtl/text_console_cursor_top.sv
sim/text_console_cursor_top_tb.sv
